[hdl/ecf_pkg.sv]
// ----------------------------------------------------------------------------
// ecf_pkg: shared types and constants of the ECF hold decision block
// Field widths, register map, sequencer states and the job record that is
// passed from the classifier to the decision engine.
// ----------------------------------------------------------------------------
package ecf_pkg;

	localparam int unsigned IN_TDATA_W  = 280;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	localparam int unsigned CWND_W  = 16;
	localparam int unsigned MSS_W   = 16;
	localparam int unsigned PKT_W   = 16;
	localparam int unsigned RAW_W   = 32;
	localparam int unsigned SRTT_W  = 29;
	localparam int unsigned VAR_W   = 31;
	localparam int unsigned BYTES_W = 32;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned BETA_W  = 8;

	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 32;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int unsigned SCL_A_W = 64;
	localparam int unsigned SCL_B_W = BETA_W + 1;
	localparam int unsigned SCL_P_W = SCL_A_W + SCL_B_W;

	localparam int unsigned LHS_W  = 62;
	localparam int unsigned RHS_W  = 64;
	localparam int unsigned LHSS_W = 61;
	localparam int unsigned RHSS_W = 64;

	localparam logic [0:0]        REG_BETA   = 1'b0;
	localparam logic [BETA_W-1:0] BETA_RESET = 8'd4;

	typedef struct packed {
		logic               same_path;
		logic [CWND_W-1:0]  cwnd_f;
		logic [CWND_W-1:0]  cwnd_s;
		logic [MSS_W-1:0]   mss;
		logic [SRTT_W-1:0]  srtt_f;
		logic [SRTT_W-1:0]  srtt_s;
		logic [SUM_W-1:0]   slow_sum;
		logic [SUM_W-1:0]   fast_sum;
		logic [BYTES_W-1:0] meta_q;
		logic [BYTES_W-1:0] sub_q;
		logic [PKT_W-1:0]   pk_diff;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_WF,
		B_WS,
		B_PK,
		B_BL,
		B_LHS,
		B_RHS,
		B_SL,
		B_SR,
		B_CMP,
		B_LS,
		B_RS,
		B_DEC,
		B_OUT
	} bstate_t;

endpackage

[hdl/ecf_front.sv]
// ----------------------------------------------------------------------------
// ecf_front: input beat classifier
// Unpacks an input beat, scales the RTT figures and folds the sums and the
// packet difference that the decision engine needs into one job record.
// ----------------------------------------------------------------------------
module ecf_front import ecf_pkg::*; (
	input  logic                  s_axis_tvalid,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                  q_full,
	output logic                  s_axis_tready,
	output logic                  push,
	output job_t                  job
);

	logic [RAW_W-1:0] f_srtt_raw, f_var_raw, s_srtt_raw, s_var_raw;
	logic [PKT_W-1:0] meta_pk, sub_pk;
	logic [VAR_W-1:0] var_f, var_s, delta;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	always_comb begin
		f_srtt_raw = s_axis_tdata[48:17];
		f_var_raw  = s_axis_tdata[80:49];
		s_srtt_raw = s_axis_tdata[128:97];
		s_var_raw  = s_axis_tdata[160:129];
		meta_pk    = s_axis_tdata[256:241];
		sub_pk     = s_axis_tdata[272:257];
		var_f      = f_var_raw[RAW_W-1:1];
		var_s      = s_var_raw[RAW_W-1:1];
		delta      = (var_f > var_s) ? var_f : var_s;

		job.same_path = s_axis_tdata[0];
		job.cwnd_f    = s_axis_tdata[16:1];
		job.cwnd_s    = s_axis_tdata[96:81];
		job.mss       = s_axis_tdata[176:161];
		job.srtt_f    = f_srtt_raw[RAW_W-1:3];
		job.srtt_s    = s_srtt_raw[RAW_W-1:3];
		job.slow_sum  = SUM_W'(job.srtt_s) + SUM_W'(delta);
		job.fast_sum  = SUM_W'({job.srtt_f, 1'b0}) + SUM_W'(delta);
		job.meta_q    = s_axis_tdata[208:177];
		job.sub_q     = s_axis_tdata[240:209];
		job.pk_diff   = (meta_pk > sub_pk) ? (meta_pk - sub_pk) : '0;
	end

endmodule

[hdl/ecf_queue.sv]
// ----------------------------------------------------------------------------
// ecf_queue: job queue
// Small register FIFO between the classifier and the decision engine.
// ----------------------------------------------------------------------------
module ecf_queue import ecf_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic head_valid,
	output logic full
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/ecf_back.sv]
// ----------------------------------------------------------------------------
// ecf_back: decision engine
// Steps one job through a shared 33x32 multiplier and a 64x9 scaler, runs
// the completion-time tests that the job needs, keeps the waiting flag and drives the result
// register.
// ----------------------------------------------------------------------------
module ecf_back import ecf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  job_t                   head,
	input  logic                   head_valid,
	input  logic [BETA_W-1:0]      beta,
	input  logic                   m_axis_tready,
	output logic                   pop,
	output logic                   m_axis_tvalid,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	bstate_t state_q, state_nx;

	job_t               job_q;
	logic [31:0]        wf_q, ws_q, pk_q, backlog_q;
	logic [LHS_W-1:0]   lhs_q;
	logic [RHS_W-1:0]   rhs_q;
	logic [LHSS_W-1:0]  ls_q;
	logic [RHSS_W-1:0]  rs_q;
	logic [SCL_P_W-1:0] lb_q, rb_q;
	logic               res_send_q, res_flag_q;
	logic               flag_q, out_valid_q, out_send_q, out_wait_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [SCL_A_W-1:0] scl_a;
	logic [SCL_B_W-1:0] scl_b;
	logic [SCL_P_W-1:0] scl_p;
	logic [32:0]        minus;
	logic [33:0]        bl_diff;
	logic [31:0]        xf, xs;
	logic               out_load, fast_wins, slow_too_slow;

	assign mul_p         = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	assign scl_p         = SCL_P_W'(scl_a) * SCL_P_W'(scl_b);
	assign minus         = {1'b0, job_q.sub_q} + {1'b0, pk_q};
	assign bl_diff       = {2'b0, job_q.meta_q} - {1'b0, minus};
	assign xf            = (backlog_q > wf_q) ? backlog_q : wf_q;
	assign xs            = (backlog_q > ws_q) ? backlog_q : ws_q;
	assign fast_wins     = (lb_q < rb_q);
	assign slow_too_slow = (RHSS_W'(ls_q) >= rs_q);
	assign out_load      = (state_q == B_OUT) && (!out_valid_q || m_axis_tready);
	assign pop           = (state_q == B_IDLE) && head_valid;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_wait_q, out_send_q};

	always_comb begin
		state_nx = state_q;
		case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					state_nx = head.same_path ? B_OUT : B_WF;
				end
			end
			B_WF:  state_nx = B_WS;
			B_WS:  state_nx = B_PK;
			B_PK:  state_nx = B_BL;
			B_BL:  state_nx = B_LHS;
			B_LHS: state_nx = B_RHS;
			B_RHS: state_nx = B_SL;
			B_SL:  state_nx = B_SR;
			B_SR:  state_nx = B_CMP;
			B_CMP: state_nx = fast_wins ? B_LS : B_OUT;
			B_LS:  state_nx = B_RS;
			B_RS:  state_nx = B_DEC;
			B_DEC: state_nx = B_OUT;
			B_OUT: begin
				if (out_load) begin
					state_nx = B_IDLE;
				end
			end
			default: state_nx = B_IDLE;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		scl_a = '0;
		scl_b = '0;
		case (state_q)
			B_WF: begin
				mul_a = MUL_A_W'(job_q.cwnd_f);
				mul_b = MUL_B_W'(job_q.mss);
			end
			B_WS: begin
				mul_a = MUL_A_W'(job_q.cwnd_s);
				mul_b = MUL_B_W'(job_q.mss);
			end
			B_PK: begin
				mul_a = MUL_A_W'(job_q.pk_diff);
				mul_b = MUL_B_W'(job_q.mss);
			end
			B_LHS: begin
				mul_a = {1'b0, xf} + {1'b0, wf_q};
				mul_b = MUL_B_W'(job_q.srtt_f);
			end
			B_RHS: begin
				mul_a = MUL_A_W'(wf_q);
				mul_b = job_q.slow_sum;
			end
			B_SL: begin
				scl_a = SCL_A_W'(lhs_q);
				scl_b = SCL_B_W'(beta);
			end
			B_SR: begin
				scl_a = rhs_q;
				scl_b = SCL_B_W'(beta) + SCL_B_W'(flag_q);
			end
			B_LS: begin
				mul_a = MUL_A_W'(xs);
				mul_b = MUL_B_W'(job_q.srtt_s);
			end
			B_RS: begin
				mul_a = MUL_A_W'(ws_q);
				mul_b = job_q.fast_sum;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q      <= head;
			res_send_q <= 1'b1;
			res_flag_q <= flag_q;
		end
		case (state_q)
			B_WF:  wf_q  <= mul_p[31:0];
			B_WS:  ws_q  <= mul_p[31:0];
			B_PK:  pk_q  <= mul_p[31:0];
			B_BL:  backlog_q <= bl_diff[33] ? '0 : bl_diff[31:0];
			B_LHS: lhs_q <= mul_p[LHS_W-1:0];
			B_RHS: rhs_q <= mul_p[RHS_W-1:0];
			B_SL:  lb_q  <= scl_p;
			B_SR:  rb_q  <= scl_p;
			B_CMP: begin
				if (!fast_wins) begin
					res_send_q <= 1'b1;
					res_flag_q <= 1'b0;
				end
			end
			B_LS:  ls_q  <= mul_p[LHSS_W-1:0];
			B_RS:  rs_q  <= mul_p[RHSS_W-1:0];
			B_DEC: begin
				if (slow_too_slow) begin
					res_send_q <= 1'b0;
					res_flag_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_send_q <= res_send_q;
			out_wait_q <= res_flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_load) begin
				flag_q      <= res_flag_q;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/ecf_subflow_hold_decision.sv]
// ----------------------------------------------------------------------------
// ecf_subflow_hold_decision: earliest-completion-first hold decision
// One input beat carries the fastest and the chosen subflow statistics and
// the queue figures; one output beat says send (bit 0 set) or hold, with
// the waiting flag after the decision in bit 1. Both completion tests run
// unless the chosen path wins the first test, and none runs when the
// default pick already is the fastest path; the decision engine steps every
// product through one shared 33x32 multiplier and one 64x9 scaler. The
// classifier and a short job queue keep taking input beats while a decision
// is in progress, and a finished decision waits in its own output register.
// beta_reciprocal sits at byte address 0 and resets to 4.
// ----------------------------------------------------------------------------
module ecf_subflow_hold_decision import ecf_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// same_path, fast_cwnd, fast_srtt_raw, fast_rttvar_raw, slow_cwnd,
	// slow_srtt_raw, slow_rttvar_raw, seg_size, meta_queued_bytes,
	// subflow_queued_bytes, meta_packets_out, subflow_packets_out, pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// send_on_chosen, waiting_now, pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	logic [BETA_W-1:0] beta_q;
	logic              push, pop, q_full, head_valid;
	job_t              push_job, head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BETA) ? APB_DATA_W'(beta_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_BETA) begin
			beta_q <= pwdata[BETA_W-1:0];
		end
	end

	ecf_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.s_axis_tready (s_axis_tready),
		.push          (push),
		.job           (push_job)
	);

	ecf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	ecf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.beta          (beta_q),
		.m_axis_tready (m_axis_tready),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

[hdl/ecf_chk.sv]
// ----------------------------------------------------------------------------
// ecf_chk: port checker
// Watches the result stream and the register port of the top level.
// ----------------------------------------------------------------------------
module ecf_chk import ecf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	input  logic [APB_DATA_W-1:0]  prdata,
	input  logic                   pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_hold_sets_wait: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[1])
		else $error("hold decision without waiting flag");

	a_beta_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_BETA
		|=> paddr[2] != REG_BETA || prdata[BETA_W-1:0] == $past(pwdata[BETA_W-1:0]))
		else $error("beta register readback mismatch");

endmodule

bind ecf_subflow_hold_decision ecf_chk u_chk (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the ECF subflow hold decision block
// Drives segment statistics on the input stream and beta_reciprocal over APB,
// predicts each send/hold decision and the waiting flag from its own model of
// the completion-time tests, and checks every output beat in order. A short
// directed run hits the extremes, the tie and hysteresis cases and the zero
// window and segment size cases; random phases follow at several register
// settings, with random idling on both sides, idle-free phases and one long
// receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
	import ecf_pkg::*;

	localparam int unsigned PAD_W = IN_TDATA_W - 1 - 2 * CWND_W - 4 * RAW_W - MSS_W
		- 2 * BYTES_W - 2 * PKT_W;
	localparam logic [APB_ADDR_W-1:0] BETA_ADDR  = APB_ADDR_W'(4 * REG_BETA);
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = APB_ADDR_W'(4);
	localparam int unsigned PHASES          = 6;
	localparam int unsigned PHASE_SEGMENTS  = 175;
	localparam int unsigned MAX_GAP         = 17;
	localparam int unsigned STALL_AT_BEAT   = 300;
	localparam int unsigned STALL_CYCLES    = 400;
	localparam int unsigned DRAIN_CYCLES    = 16;

	typedef struct packed {
		logic [PAD_W-1:0]   pad;
		logic [PKT_W-1:0]   subflow_packets_out;
		logic [PKT_W-1:0]   meta_packets_out;
		logic [BYTES_W-1:0] subflow_queued_bytes;
		logic [BYTES_W-1:0] meta_queued_bytes;
		logic [MSS_W-1:0]   seg_size;
		logic [RAW_W-1:0]   slow_rttvar_raw;
		logic [RAW_W-1:0]   slow_srtt_raw;
		logic [CWND_W-1:0]  slow_cwnd;
		logic [RAW_W-1:0]   fast_rttvar_raw;
		logic [RAW_W-1:0]   fast_srtt_raw;
		logic [CWND_W-1:0]  fast_cwnd;
		logic               same_path;
	} segment_t;

	typedef struct packed {
		logic waiting_now;
		logic send_on_chosen;
	} decision_t;

	class hold_decision_board;
		logic [BETA_W-1:0] beta_recip;
		bit                waiting;
		decision_t         expected_decisions[$];
		int unsigned       mismatches;

		function new();
			beta_recip  = BETA_RESET;
			waiting     = 1'b0;
			mismatches  = 0;
		endfunction

		function void note_error(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		function int unsigned pending();
			return expected_decisions.size();
		endfunction

		function void note_segment(segment_t seg);
			logic [127:0] mss, srtt_f, srtt_s, delta, wf, ws;
			logic [127:0] minus, backlog, xf, xs, lhs, rhs;
			decision_t want;
			want.send_on_chosen = 1'b1;
			if (!seg.same_path) begin
				mss    = seg.seg_size;
				srtt_f = seg.fast_srtt_raw >> 3;
				srtt_s = seg.slow_srtt_raw >> 3;
				delta  = (seg.fast_rttvar_raw > seg.slow_rttvar_raw) ?
					seg.fast_rttvar_raw >> 1 : seg.slow_rttvar_raw >> 1;
				wf     = seg.fast_cwnd * mss;
				ws     = seg.slow_cwnd * mss;
				minus  = seg.subflow_queued_bytes;
				if (seg.meta_packets_out > seg.subflow_packets_out)
					minus = minus + (seg.meta_packets_out - seg.subflow_packets_out) * mss;
				backlog = (seg.meta_queued_bytes > minus) ? seg.meta_queued_bytes - minus : '0;
				xf  = (backlog > wf) ? backlog : wf;
				lhs = srtt_f * (xf + wf);
				rhs = wf * (srtt_s + delta);
				if (beta_recip * lhs < (beta_recip + waiting) * rhs) begin
					xs = (backlog > ws) ? backlog : ws;
					if (srtt_s * xs >= ws * (2 * srtt_f + delta)) begin
						waiting = 1'b1;
						want.send_on_chosen = 1'b0;
					end
				end else begin
					waiting = 1'b0;
				end
			end
			want.waiting_now = waiting;
			expected_decisions.push_back(want);
		endfunction

		function void check_decision(logic [OUT_TDATA_W-1:0] beat);
			decision_t got, want;
			got = decision_t'(beat[1:0]);
			if (expected_decisions.size() == 0) begin
				note_error($sformatf("decision beat %b with nothing expected", beat));
				return;
			end
			want = expected_decisions.pop_front();
			if (got.send_on_chosen !== want.send_on_chosen)
				note_error($sformatf("send_on_chosen expected %b got %b",
					want.send_on_chosen, got.send_on_chosen));
			if (got.waiting_now !== want.waiting_now)
				note_error($sformatf("waiting_now expected %b got %b",
					want.waiting_now, got.waiting_now));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// same_path, fast_cwnd, fast_srtt_raw, fast_rttvar_raw, slow_cwnd,
	// slow_srtt_raw, slow_rttvar_raw, seg_size, meta_queued_bytes,
	// subflow_queued_bytes, meta_packets_out, subflow_packets_out, pad
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// send_on_chosen, waiting_now, pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	hold_decision_board board;
	bit idle_on = 1'b1;

	ecf_subflow_hold_decision u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [31:0] corner_value(int unsigned w);
		logic [31:0] top;
		top = 32'hFFFF_FFFF >> (32 - w);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return top;
			2: return 32'd1;
			default: return $urandom & top;
		endcase
	endfunction

	function automatic segment_t shaped_segment(bit same, int unsigned cwf, int unsigned sf_us,
		int unsigned vf_us, int unsigned cws, int unsigned ss_us, int unsigned vs_us,
		int unsigned mss, int unsigned mq, int unsigned sq, int unsigned mp, int unsigned sp);
		segment_t s;
		s = '0;
		s.same_path            = same;
		s.fast_cwnd            = CWND_W'(cwf);
		s.fast_srtt_raw        = sf_us << 3;
		s.fast_rttvar_raw      = vf_us << 1;
		s.slow_cwnd            = CWND_W'(cws);
		s.slow_srtt_raw        = ss_us << 3;
		s.slow_rttvar_raw      = vs_us << 1;
		s.seg_size             = MSS_W'(mss);
		s.meta_queued_bytes    = mq;
		s.subflow_queued_bytes = sq;
		s.meta_packets_out     = PKT_W'(mp);
		s.subflow_packets_out  = PKT_W'(sp);
		return s;
	endfunction

	function automatic segment_t random_segment();
		segment_t s;
		logic [9*32-1:0] noise;
		int unsigned kind, rtt_f, rtt_s;
		kind = $urandom_range(0, 19);
		s = '0;
		if (kind < 3) begin
			noise = {$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			s = noise[IN_TDATA_W-1:0];
			s.pad = '0;
		end else if (kind < 6) begin
			s.same_path            = 1'($urandom_range(0, 1));
			s.fast_cwnd            = CWND_W'(corner_value(CWND_W));
			s.fast_srtt_raw        = corner_value(RAW_W);
			s.fast_rttvar_raw      = corner_value(RAW_W);
			s.slow_cwnd            = CWND_W'(corner_value(CWND_W));
			s.slow_srtt_raw        = corner_value(RAW_W);
			s.slow_rttvar_raw      = corner_value(RAW_W);
			s.seg_size             = MSS_W'(corner_value(MSS_W));
			s.meta_queued_bytes    = corner_value(BYTES_W);
			s.subflow_queued_bytes = corner_value(BYTES_W);
			s.meta_packets_out     = PKT_W'(corner_value(PKT_W));
			s.subflow_packets_out  = PKT_W'(corner_value(PKT_W));
		end else begin
			rtt_f = $urandom_range(200, 50000);
			rtt_s = rtt_f * $urandom_range(2, 40) / 8;
			s.same_path       = ($urandom_range(0, 9) == 0);
			s.fast_cwnd       = CWND_W'($urandom_range(1, 80));
			s.slow_cwnd       = CWND_W'($urandom_range(1, 80));
			s.fast_srtt_raw   = rtt_f * 8 + $urandom_range(0, 7);
			s.slow_srtt_raw   = rtt_s * 8 + $urandom_range(0, 7);
			s.fast_rttvar_raw = $urandom_range(0, rtt_f / 4) * 2 + $urandom_range(0, 1);
			s.slow_rttvar_raw = $urandom_range(0, rtt_s / 4) * 2 + $urandom_range(0, 1);
			s.seg_size        = MSS_W'(($urandom_range(0, 7) == 0) ?
				$urandom_range(0, 65535) : $urandom_range(536, 1460));
			s.subflow_packets_out = PKT_W'($urandom_range(0, 300));
			s.meta_packets_out    = PKT_W'(($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 300) : s.subflow_packets_out + $urandom_range(0, 60));
			s.subflow_queued_bytes = $urandom_range(0, 400000);
			s.meta_queued_bytes    = s.subflow_queued_bytes + ($urandom_range(0, 1) ?
				$urandom_range(0, 200000) : $urandom_range(0, 4000000));
		end
		return s;
	endfunction

	task automatic send_segment(input segment_t seg);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= seg;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		board.note_segment(seg);
	endtask

	task automatic quiet_input();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_decisions();
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write the addressed register, then read beta_reciprocal back in a back-to-back transfer
	task automatic program_register(input logic [APB_ADDR_W-1:0] addr,
		input logic [BETA_W-1:0] value);
		logic [APB_DATA_W-1:0] word;
		word = $urandom;
		word[BETA_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == BETA_ADDR)
			board.beta_recip = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= BETA_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[BETA_W-1:0] !== board.beta_recip)
			board.note_error($sformatf("beta_reciprocal read expected %0d got %0d",
				board.beta_recip, prdata[BETA_W-1:0]));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int unsigned gap, beats;
		bit stalled;
		beats   = 0;
		stalled = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (!stalled && beats == STALL_AT_BEAT) begin
				gap     = STALL_CYCLES;
				stalled = 1'b1;
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			board.check_decision(m_axis_tdata);
			beats++;
		end
	end

	initial begin
		segment_t seg, hold_case, tie_case;
		logic [BETA_W-1:0] phase_beta [PHASES];
		board = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		hold_case = shaped_segment(0, 10, 100, 0, 10, 300, 0, 1000, 0, 0, 0, 0);
		tie_case  = shaped_segment(0, 10, 100, 0, 10, 200, 0, 1000, 0, 0, 0, 0);
		seg = '1;
		seg.pad = '0;
		send_segment(seg);
		seg.same_path = 1'b0;
		send_segment(seg);
		send_segment('0);
		send_segment(hold_case);
		send_segment(tie_case);
		send_segment(shaped_segment(0, 10, 100, 100, 10, 150, 0, 1000, 0, 0, 0, 0));
		send_segment(shaped_segment(0, 10, 300, 0, 10, 100, 0, 1000, 0, 0, 0, 0));
		send_segment(tie_case);
		send_segment(hold_case);
		send_segment(shaped_segment(0, 10, 100, 0, 10, 300, 0, 0, 500000, 0, 0, 0));
		send_segment(hold_case);
		send_segment(shaped_segment(0, 0, 100, 0, 10, 300, 0, 1000, 0, 0, 0, 0));
		send_segment(hold_case);
		send_segment(shaped_segment(0, 10, 100, 0, 0, 300, 0, 1000, 0, 0, 0, 0));
		send_segment(shaped_segment(0, 10, 100, 0, 10, 300, 0, 1000, 500000, 100000, 50, 10));
		send_segment(shaped_segment(0, 10, 100, 0, 10, 1000, 0, 1000, 150000, 100000, 10, 50));
		send_segment(shaped_segment(0, 10, 100, 0, 10, 300, 0, 1000, 1000, 5000, 0, 0));
		send_segment(shaped_segment(0, 10, 100, 50, 10, 300, 10, 1000, 0, 0, 0, 0));
		send_segment(shaped_segment(0, 10, 100, 10, 10, 300, 150, 1000, 0, 0, 0, 0));
		seg = hold_case;
		seg.same_path = 1'b1;
		send_segment(seg);

		phase_beta = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd0, 8'd4};
		phase_beta[4] = BETA_W'($urandom_range(3, 254));
		for (int p = 0; p < PHASES; p++) begin
			quiet_input();
			drain_decisions();
			if (p == 0)
				program_register(SPARE_ADDR, BETA_W'($urandom));
			program_register(BETA_ADDR, phase_beta[p]);
			idle_on = (p % 2 == 0);
			for (int n = 0; n < PHASE_SEGMENTS; n++)
				send_segment(random_segment());
		end
		quiet_input();
		drain_decisions();

		if (board.mismatches == 0 && board.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
